// ===== sv/imas_pkg.sv =====
`timescale 1ns / 1ps

package imas_pkg;

   // Default store depth
   localparam int CAPACITY_DEF = 2048;

   // Fixed field widths
   localparam int MODE_W = 2;
   localparam int POS_W  = 11;
   localparam int VAL_W  = 32;
   localparam int LEN_W  = 12;
   localparam int SUM_W  = 42;
   localparam int REQ_W  = 48;
   localparam int RSP_W  = 56;

   // Operation codes
   typedef enum logic [MODE_W-1:0] {
      MODE_SET    = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_WALK  = 2'd1,
      ST_DRAIN = 2'd2,
      ST_REPLY = 2'd3
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic start;
      logic walk;
      logic finish;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic more;
   } stat_type;

endpackage

// ===== sv/imas_ctrl.sv =====
`timescale 1ns / 1ps

module imas_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  imas_pkg::stat_type stat,
   output imas_pkg::cmd_type  cmd
);

   imas_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         imas_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = imas_pkg::ST_WALK;
         end
         imas_pkg::ST_WALK: begin
            if (!stat.more) state_in = imas_pkg::ST_DRAIN;
         end
         imas_pkg::ST_DRAIN: begin
            state_in = imas_pkg::ST_REPLY;
         end
         imas_pkg::ST_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) state_in = imas_pkg::ST_IDLE;
         end
         default: begin
            state_in = imas_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands and handshake outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         imas_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         imas_pkg::ST_WALK: begin
            cmd.walk   = stat.more;
            cmd.finish = !stat.more;
         end
         imas_pkg::ST_REPLY: begin
            cmd.load_rsp = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Hold the result until the transaction completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp)      rsp_valid_in = 1'b1;
      else if (rsp_tready)   rsp_valid_in = 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imas_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/imas_dpath.sv =====
`timescale 1ns / 1ps

module imas_dpath #(
   parameter int CAPACITY = imas_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  imas_pkg::cmd_type                 cmd,
   output imas_pkg::stat_type                stat,
   input  logic [imas_pkg::MODE_W-1:0]       req_mode,
   input  logic [imas_pkg::POS_W-1:0]        req_position,
   input  logic signed [imas_pkg::VAL_W-1:0] req_item_value,
   output logic                              rsp_status,
   output logic [imas_pkg::LEN_W-1:0]        rsp_list_length,
   output logic [imas_pkg::SUM_W-1:0]        rsp_best_sum
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int XW   = CW + imas_pkg::POS_W;
   localparam int RW0  = AW + imas_pkg::VAL_W;
   localparam int RW   = (RW0 > imas_pkg::SUM_W) ? RW0 : imas_pkg::SUM_W;
   localparam int VW   = imas_pkg::VAL_W;

   // Entry memory, one write and one registered read per cycle
   logic [VW-1:0] store_ff [CAPACITY];
   logic [VW-1:0] rd_ff;

   // Captured operation
   imas_pkg::mode_type       mode_ff;
   logic [imas_pkg::POS_W-1:0] pos_ff;
   logic [VW-1:0]            val_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] wa_ff, wa_in;
   logic          wsrc_ff, wsrc_in;
   logic          sv1_ff, sv1_in;
   logic          sv2_ff, sv2_in;
   logic [RW-1:0] run_ff, run_in;
   logic [RW-1:0] best_ff, best_in;
   logic          rej_ff, rej_in;

   logic [imas_pkg::LEN_W-1:0] len_ff;
   logic [imas_pkg::SUM_W-1:0] sum_ff;
   logic                       status_ff;

   logic [XW-1:0]   pos_x, cnt_x, idx_x, cap_x;
   logic [CW:0]     idx_dn, idx_up;
   logic [AW-1:0]   ra;
   logic            ok;
   logic signed [RW:0] run_sum;
   logic [CW+imas_pkg::LEN_W-1:0] cnt_wide;
   logic [RW+imas_pkg::SUM_W-1:0] best_wide;

   // Common width for position and count compares
   assign pos_x  = {{CW{1'b0}}, pos_ff};
   assign cnt_x  = {{imas_pkg::POS_W{1'b0}}, count_ff};
   assign idx_x  = {{imas_pkg::POS_W{1'b0}}, idx_ff};
   assign cap_x  = XW'(CAPACITY);
   assign idx_dn = {1'b0, idx_ff} - 1'b1;
   assign idx_up = {1'b0, idx_ff} + 1'b1;

   // Legality of the captured operation
   always_comb begin
      case (mode_ff)
         imas_pkg::MODE_SET:    ok = pos_x < cnt_x;
         imas_pkg::MODE_INSERT: ok = (pos_x <= cnt_x) && (cnt_x < cap_x);
         imas_pkg::MODE_DELETE: ok = pos_x < cnt_x;
         default:               ok = 1'b1;
      endcase
   end

   // Walk continues while entries remain to move or sum
   always_comb begin
      case (mode_ff)
         imas_pkg::MODE_INSERT: stat.more = ok && (idx_x > pos_x);
         imas_pkg::MODE_DELETE: stat.more = ok && ({1'b0, idx_up} < {1'b0, cnt_x[CW:0]});
         imas_pkg::MODE_QUERY:  stat.more = idx_x < cnt_x;
         default:               stat.more = 1'b0;
      endcase
   end

   // Read address for this walk step
   always_comb begin
      case (mode_ff)
         imas_pkg::MODE_INSERT: ra = idx_dn[AW-1:0];
         imas_pkg::MODE_DELETE: ra = idx_up[AW-1:0];
         default:               ra = idx_ff[AW-1:0];
      endcase
   end

   // Running sum, clamped at zero
   assign run_sum = $signed({1'b0, run_ff}) + $signed({{(RW+1-VW){rd_ff[VW-1]}}, rd_ff});

   // Walk, finish and write scheduling
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      pend_in  = 1'b0;
      wa_in    = wa_ff;
      wsrc_in  = 1'b0;
      sv1_in   = 1'b0;
      rej_in   = rej_ff;
      if (cmd.start) begin
         case (imas_pkg::mode_type'(req_mode))
            imas_pkg::MODE_INSERT: idx_in = count_ff;
            imas_pkg::MODE_DELETE: idx_in = CW'({{CW{1'b0}}, req_position});
            default:               idx_in = '0;
         endcase
      end
      if (cmd.walk) begin
         case (mode_ff)
            imas_pkg::MODE_INSERT: begin
               pend_in = 1'b1;
               wa_in   = idx_ff[AW-1:0];
               idx_in  = idx_dn[CW-1:0];
            end
            imas_pkg::MODE_DELETE: begin
               pend_in = 1'b1;
               wa_in   = idx_ff[AW-1:0];
               idx_in  = idx_up[CW-1:0];
            end
            default: begin
               sv1_in = 1'b1;
               idx_in = idx_up[CW-1:0];
            end
         endcase
      end
      if (cmd.finish) begin
         rej_in = !ok;
         if (ok) begin
            case (mode_ff)
               imas_pkg::MODE_SET: begin
                  pend_in = 1'b1;
                  wsrc_in = 1'b1;
                  wa_in   = pos_x[AW-1:0];
               end
               imas_pkg::MODE_INSERT: begin
                  pend_in  = 1'b1;
                  wsrc_in  = 1'b1;
                  wa_in    = pos_x[AW-1:0];
                  count_in = count_ff + 1'b1;
               end
               imas_pkg::MODE_DELETE: begin
                  count_in = count_ff - 1'b1;
               end
               default: begin
                  count_in = count_ff;
               end
            endcase
         end
      end
   end

   // Kadane stages: accumulate, then track the best
   always_comb begin
      sv2_in  = sv1_ff;
      run_in  = run_ff;
      best_in = best_ff;
      if (cmd.start) begin
         run_in  = '0;
         best_in = '0;
      end else begin
         if (sv1_ff) run_in = run_sum[RW] ? '0 : run_sum[RW-1:0];
         if (sv2_ff && (run_ff > best_ff)) best_in = run_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) store_ff[wa_ff] <= wsrc_ff ? val_ff : rd_ff;
      rd_ff <= store_ff[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
         sv1_ff   <= 1'b0;
         sv2_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
         sv1_ff   <= sv1_in;
         sv2_ff   <= sv2_in;
      end
   end

   // Capture the request and register the walk state
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff <= imas_pkg::mode_type'(req_mode);
         pos_ff  <= req_position;
         val_ff  <= req_item_value;
      end
      idx_ff  <= idx_in;
      wa_ff   <= wa_in;
      wsrc_ff <= wsrc_in;
      run_ff  <= run_in;
      best_ff <= best_in;
      rej_ff  <= rej_in;
   end

   assign cnt_wide  = {{imas_pkg::LEN_W{1'b0}}, count_ff};
   assign best_wide = {{imas_pkg::SUM_W{1'b0}}, best_ff};

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff <= rej_ff;
         len_ff    <= cnt_wide[imas_pkg::LEN_W-1:0];
         sum_ff    <= (mode_ff == imas_pkg::MODE_QUERY) ?
                      best_wide[imas_pkg::SUM_W-1:0] : '0;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_list_length = len_ff;
   assign rsp_best_sum    = sum_ff;

endmodule

// ===== sv/indexed_array_with_max_subarray_unit.sv =====
`timescale 1ns / 1ps
// Each operation walks n entries after the request is accepted, where n is:
//   set 0, insert length - position, delete length - position - 1, query length;
//   a rejected operation has n = 0.
// The entry memory moves or sums one entry per cycle during a walk; a new request
//   is accepted only after the previous result is loaded into the output register.
// Reset (synchronous, active high) empties the list; entry memory is not cleared.

module indexed_array_with_max_subarray_unit #(
   parameter int CAPACITY = imas_pkg::CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [1:0] mode, [12:2] position, [44:13] item_value, [47:45] zero
   input  logic [imas_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [0] status, [12:1] list_length, [54:13] best_sum, [55] zero
   output logic [imas_pkg::RSP_W-1:0] rsp_tdata
);

   imas_pkg::cmd_type          cmd;
   imas_pkg::stat_type         stat;
   logic                       rsp_status;
   logic [imas_pkg::LEN_W-1:0] rsp_list_length;
   logic [imas_pkg::SUM_W-1:0] rsp_best_sum;

   imas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   imas_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_tdata[1:0]),
      .req_position    (req_tdata[12:2]),
      .req_item_value  (req_tdata[44:13]),
      .rsp_status      (rsp_status),
      .rsp_list_length (rsp_list_length),
      .rsp_best_sum    (rsp_best_sum)
   );

   // Pack the result fields
   assign rsp_tdata = {1'b0, rsp_best_sum, rsp_list_length, rsp_status};

endmodule

// ===== sv/imas_check.sv =====
`timescale 1ns / 1ps

module imas_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [imas_pkg::REQ_W-1:0] req_tdata,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [imas_pkg::RSP_W-1:0] rsp_tdata
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // One operation at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // No result rises early after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid) ##1 !$rose(rsp_tvalid))
      else $error("result too early");

   // A nonzero best sum only comes with a completed operation
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[54:13] != '0) |-> !rsp_tdata[0])
      else $error("best sum on rejected operation");

   // Reset leaves no result pending
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind indexed_array_with_max_subarray_unit imas_check u_imas_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import imas_pkg::*;

   localparam int STALL_LIMIT = 12000;
   localparam int PRINT_LIMIT = 50;
   localparam int LONG_LEN    = 40;

   // One list operation as carried on the request channel
   typedef struct packed {
      mode_type             mode;
      logic [POS_W-1:0]     position;
      logic [VAL_W-1:0]     value;
   } list_op_t;

   // One operation result as carried on the response channel
   typedef struct packed {
      logic                 status;
      logic [LEN_W-1:0]     list_length;
      logic [SUM_W-1:0]     best_sum;
   } list_rsp_t;

   // Directed row: an operation and, where obvious, its typed-in result
   typedef struct {
      list_op_t             op;
      bit                   typed;
      list_rsp_t            want;
   } dir_row_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;

   // Shadow copy of the list
   logic signed [VAL_W-1:0] shadow_list [CAPACITY_DEF];
   int                   list_len = 0;

   list_rsp_t            pending_rsp [$];
   dir_row_t             dir_rows [$];
   bit                   calm_phase = 1'b0;
   int                   err_count = 0;
   int                   idle_cycles = 0;
   int                   n_checked = 0;
   int                   n_rejects = 0;
   int                   n_queries = 0;
   int                   peak_len = 0;

   indexed_array_with_max_subarray_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one operation to the shadow list and return its result
   function automatic list_rsp_t model_list_op(input list_op_t op);
      list_rsp_t r;
      longint    run;
      longint    best;
      r = '0;
      case (op.mode)
         MODE_SET: begin
            if (op.position < list_len) shadow_list[op.position] = op.value;
            else r.status = 1'b1;
         end
         MODE_INSERT: begin
            if (op.position > list_len || list_len >= CAPACITY_DEF) begin
               r.status = 1'b1;
            end else begin
               for (int i = list_len; i > op.position; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[op.position] = op.value;
               list_len++;
            end
         end
         MODE_DELETE: begin
            if (op.position >= list_len) begin
               r.status = 1'b1;
            end else begin
               for (int i = op.position; i + 1 < list_len; i++) shadow_list[i] = shadow_list[i+1];
               list_len--;
            end
         end
         default: begin
            // Kadane scan with the running sum floored at zero
            run  = 0;
            best = 0;
            for (int i = 0; i < list_len; i++) begin
               run = run + shadow_list[i];
               if (run < 0) run = 0;
               if (run > best) best = run;
            end
            r.best_sum = best[SUM_W-1:0];
         end
      endcase
      r.list_length = list_len[LEN_W-1:0];
      return r;
   endfunction

   function automatic list_op_t mk_op(input mode_type m, input int p, input logic [31:0] v);
      list_op_t op;
      op.mode     = m;
      op.position = p[POS_W-1:0];
      op.value    = v;
      return op;
   endfunction

   function automatic dir_row_t row(input mode_type m, input int p, input logic [31:0] v,
                                    input bit typed = 1'b0, input logic s = 1'b0,
                                    input int len = 0, input longint sum = 0);
      dir_row_t r;
      r.op                 = mk_op(m, p, v);
      r.typed              = typed;
      r.want.status        = s;
      r.want.list_length   = len[LEN_W-1:0];
      r.want.best_sum      = sum[SUM_W-1:0];
      return r;
   endfunction

   function automatic void flag_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
      if (want !== got) begin
         if (err_count < PRINT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         err_count++;
      end
   endfunction

   // Drive one transaction, wait for it to be taken, record its expected result
   task automatic send_op(input list_op_t op, input bit typed, input list_rsp_t typed_rsp);
      int        gap;
      list_rsp_t want;
      gap = calm_phase ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, op.value, op.position, op.mode};
      do @(posedge clock); while (!req_tready);
      want = model_list_op(op);
      if (typed) want = typed_rsp;
      pending_rsp.push_back(want);
      if (op.mode == MODE_QUERY) n_queries++;
      if (list_len > peak_len) peak_len = list_len;
   endtask

   // Random operations on a short list, mostly at valid positions
   task automatic run_random(input int count);
      list_op_t op;
      int       pick;
      bit       wild;
      for (int k = 0; k < count; k++) begin
         if (k % 40 == 0) calm_phase = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         wild = ($urandom_range(0, 9) == 0);
         case ($urandom_range(0, 3))
            0: op.value = $urandom;
            1: op.value = 32'($urandom_range(0, 400)) - 32'd200;
            2: op.value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: op.value = $urandom_range(0, 1000);
         endcase
         if (pick < 35 && list_len < 48) begin
            op.mode     = MODE_INSERT;
            op.position = POS_W'($urandom_range(0, list_len));
         end else if (pick < 60 && pick >= 35) begin
            op.mode     = MODE_SET;
            op.position = (list_len == 0) ? '0 : POS_W'($urandom_range(0, list_len - 1));
         end else if (pick < 80) begin
            op.mode     = MODE_DELETE;
            op.position = (list_len == 0) ? '0 : POS_W'($urandom_range(0, list_len - 1));
         end else begin
            op.mode     = MODE_QUERY;
            op.position = POS_W'($urandom_range(0, 2047));
         end
         if (wild) op.position = POS_W'($urandom_range(0, 2047));
         send_op(op, 1'b0, '0);
      end
   endtask

   // Response side: random stall before each transaction
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = calm_phase ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      list_rsp_t want;
      list_rsp_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = rsp_tdata[0];
         got.list_length = rsp_tdata[12:1];
         got.best_sum    = rsp_tdata[54:13];
         if (pending_rsp.size() == 0) begin
            if (err_count < PRINT_LIMIT)
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_tdata);
            err_count++;
         end else begin
            want = pending_rsp.pop_front();
            flag_field("status", 64'(want.status), 64'(got.status));
            flag_field("list_length", 64'(want.list_length), 64'(got.list_length));
            flag_field("best_sum", 64'(want.best_sum), 64'(got.best_sum));
            n_checked++;
            if (want.status) n_rejects++;
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("indexed_array_with_max_subarray_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main stimulus
   initial begin
      // Empty list, rejects on empty and at the top position, extremes
      dir_rows.push_back(row(MODE_QUERY,  0,    32'd0,         1'b1, 1'b0, 0, 0));
      dir_rows.push_back(row(MODE_SET,    0,    32'd1,         1'b1, 1'b1, 0, 0));
      dir_rows.push_back(row(MODE_DELETE, 0,    32'd0,         1'b1, 1'b1, 0, 0));
      dir_rows.push_back(row(MODE_INSERT, 1,    32'd1,         1'b1, 1'b1, 0, 0));
      dir_rows.push_back(row(MODE_INSERT, 0,    32'h7FFF_FFFF, 1'b1, 1'b0, 1, 0));
      dir_rows.push_back(row(MODE_INSERT, 1,    32'h8000_0000, 1'b1, 1'b0, 2, 0));
      dir_rows.push_back(row(MODE_QUERY,  0,    32'd0,         1'b1, 1'b0, 2, 64'h7FFF_FFFF));
      dir_rows.push_back(row(MODE_SET,    2047, 32'hFFFF_FFFF, 1'b1, 1'b1, 2, 0));
      dir_rows.push_back(row(MODE_INSERT, 2047, 32'd0,         1'b1, 1'b1, 2, 0));
      dir_rows.push_back(row(MODE_DELETE, 2047, 32'd0,         1'b1, 1'b1, 2, 0));
      // Shifts at front, middle and end, checked by the shadow list
      dir_rows.push_back(row(MODE_SET,    1,    32'hFFFF_FFFF));
      dir_rows.push_back(row(MODE_INSERT, 0,    32'd5));
      dir_rows.push_back(row(MODE_INSERT, 3,    32'h7FFF_FFFF));
      dir_rows.push_back(row(MODE_QUERY,  2047, 32'hFFFF_FFFF));
      dir_rows.push_back(row(MODE_DELETE, 0,    32'd0));
      dir_rows.push_back(row(MODE_DELETE, 2,    32'd0));
      dir_rows.push_back(row(MODE_SET,    0,    32'h8000_0000));
      dir_rows.push_back(row(MODE_QUERY,  0,    32'd0));
      dir_rows.push_back(row(MODE_INSERT, 1,    32'd0));
      dir_rows.push_back(row(MODE_QUERY,  0,    32'd0));
      dir_rows.push_back(row(MODE_DELETE, 1,    32'd0));
      dir_rows.push_back(row(MODE_DELETE, 2,    32'd0));
      dir_rows.push_back(row(MODE_QUERY,  0,    32'd0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);

      run_random(85);

      // Empty the list, then build a longer one of the largest value
      calm_phase = 1'b0;
      while (list_len > 0) send_op(mk_op(MODE_DELETE, list_len - 1, 32'd0), 1'b0, '0);
      while (list_len < LONG_LEN) begin
         calm_phase = ((list_len / 8) % 2 == 1);
         send_op(mk_op(MODE_INSERT, list_len, 32'h7FFF_FFFF), 1'b0, '0);
      end
      calm_phase = 1'b0;
      // Longest walks, out-of-range positions and the largest sums
      send_op(mk_op(MODE_INSERT, 0, 32'h0000_1234), 1'b0, '0);
      send_op(mk_op(MODE_INSERT, 2047, 32'hFFFF_FFFF), 1'b0, '0);
      send_op(mk_op(MODE_QUERY, 0, 32'd0), 1'b0, '0);
      send_op(mk_op(MODE_SET, list_len - 1, 32'h8000_0000), 1'b0, '0);
      send_op(mk_op(MODE_QUERY, 0, 32'd0), 1'b0, '0);
      send_op(mk_op(MODE_DELETE, 0, 32'd0), 1'b0, '0);
      send_op(mk_op(MODE_INSERT, 0, 32'hFFFF_FFFF), 1'b0, '0);
      send_op(mk_op(MODE_SET, list_len / 2, 32'h8000_0000), 1'b0, '0);
      send_op(mk_op(MODE_QUERY, 0, 32'd0), 1'b0, '0);
      // Shrink back to a short list from the end
      while (list_len > 12) begin
         calm_phase = ((list_len / 8) % 2 == 0);
         send_op(mk_op(MODE_DELETE, list_len - 1, 32'd0), 1'b0, '0);
      end

      run_random(85);

      // Drain and settle
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Checked %0d results: %0d queries, %0d rejected operations.",
               n_checked, n_queries, n_rejects);
      $display("List grew to %0d entries with random stalls on both channels.", peak_len);
      if (err_count == 0) begin
         $display("indexed_array_with_max_subarray_unit verification clean");
      end else begin
         $display("indexed_array_with_max_subarray_unit verification failed");
      end
      $finish;
   end

endmodule
